[sv/prt_pkg.sv]
// Shared types and constants of the pointer report tracker.
// Request and result payload structs, mode and register codes, slot numbers.
// No dependencies.
package prt_pkg;

	localparam int BUTTON_SLOTS   = 8;
	localparam int REPORT_BUTTONS = 5;
	localparam int CFG_INDEX_W    = 3;
	localparam int CFG_DATA_W     = 16;

	localparam logic [2:0] SLOT_WHEEL_UP   = 3'd4;
	localparam logic [2:0] SLOT_WHEEL_DOWN = 3'd5;

	// report button bit -> slot number
	localparam logic [2:0] REPORT_SLOT [REPORT_BUTTONS] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd6};

	localparam logic signed [16:0] WHEEL_STEP_UP   = 17'sd120;
	localparam logic signed [16:0] WHEEL_STEP_DOWN = -17'sd120;

	localparam logic signed [15:0] AREA_LEFT_RESET   = 16'sd0;
	localparam logic signed [15:0] AREA_TOP_RESET    = 16'sd0;
	localparam logic signed [15:0] AREA_RIGHT_RESET  = 16'sd640;
	localparam logic signed [15:0] AREA_BOTTOM_RESET = 16'sd480;
	localparam logic signed [15:0] POS_X_RESET       = 16'sd320;
	localparam logic signed [15:0] POS_Y_RESET       = 16'sd240;

	typedef enum logic [2:0] {
		MODE_REPORT     = 3'd0,
		MODE_FRAME      = 3'd1,
		MODE_STATE      = 3'd2,
		MODE_DOWN_COUNT = 3'd3,
		MODE_UP_COUNT   = 3'd4,
		MODE_POP        = 3'd5,
		MODE_FLUSH      = 3'd6
	} mode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_AREA_LEFT   = 3'd0,
		REG_AREA_TOP    = 3'd1,
		REG_AREA_RIGHT  = 3'd2,
		REG_AREA_BOTTOM = 3'd3,
		REG_SUSPEND     = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic [4:0]         press_flags;
		logic [4:0]         release_flags;
		logic               wheel_present;
		logic signed [15:0] wheel_amount;
		logic signed [15:0] move_x;
		logic signed [15:0] move_y;
		logic [2:0]         button_index;
	} report_item_t;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] delta_x;
		logic signed [15:0] delta_y;
		logic [7:0]         held_mask;
		logic [7:0]         count_value;
		logic               event_valid;
		logic [2:0]         event_button;
		logic               event_pressed;
	} result_item_t;

endpackage

[sv/pointer_report_tracker_top.sv]
// Pointer report tracker: the whole block in one module.
// Depends on prt_pkg for payload types, mode and register codes.
//
// Usage:
//   Requests enter on in_valid/in_stall with an in_item payload; each accepted
//   request yields exactly one result on out_valid/out_stall (out_item).
//   The mode field selects report, frame, state read, down/up count read,
//   event pop or flush. Fields a mode does not produce read as zero.
//   The request is decoded and all state is updated by one pass of logic; the
//   result is registered in out_item, or in skid_q while out_item is held.
//   That single-pass update allows one request per cycle while in_stall is low.
//   Results go through a two-entry output buffer; while the receiver stalls
//   one more request is taken, then in_stall rises until a result drains.
//   Configuration (area bounds, suspend) is written by cfg_write, cfg_index and
//   cfg_data, no wait; user must write only while idle; the block won't check.
//   Reset clears buttons, counts, mask, deltas, wheel sum and the event
//   queue, puts the position at 320,240 and the area at 0,0..640,480.
//   Event queue entries are not reset; only filled entries are ever popped.
module pointer_report_tracker_top #(
	parameter int EVENT_DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  prt_pkg::report_item_t               in_item,
	output logic                                out_valid,
	input  logic                                out_stall,
	output prt_pkg::result_item_t               out_item,
	input  logic                                cfg_write,
	input  logic [prt_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [prt_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import prt_pkg::*;

	localparam int AW = $clog2(EVENT_DEPTH);
	localparam int FW = $clog2(EVENT_DEPTH + 1);
	localparam int SW = $clog2(2 * EVENT_DEPTH);
	localparam logic [FW-1:0] DEPTH_F = FW'(EVENT_DEPTH);
	localparam logic [SW-1:0] DEPTH_S = SW'(EVENT_DEPTH);
	localparam logic [AW-1:0] LAST_A  = AW'(EVENT_DEPTH - 1);

	// configuration
	logic signed [15:0] area_left_q, area_top_q, area_right_q, area_bottom_q;
	logic               suspend_q;

	// tracker state
	logic [BUTTON_SLOTS-1:0] held_q, held_d;
	logic [7:0]              press_cnt_q [BUTTON_SLOTS];
	logic [7:0]              press_cnt_d [BUTTON_SLOTS];
	logic [7:0]              release_cnt_q [BUTTON_SLOTS];
	logic [7:0]              release_cnt_d [BUTTON_SLOTS];
	logic [7:0]              mask_q, mask_d;
	logic signed [15:0]      sum_x_q, sum_x_d, sum_y_q, sum_y_d;
	logic signed [15:0]      pos_x_q, pos_x_d, pos_y_q, pos_y_d;
	logic signed [16:0]      wheel_q, wheel_d;
	logic [FW-1:0]           fill_q, fill_d;
	logic [AW-1:0]           head_q, head_d;

	// event queue: {pressed, slot}
	logic [3:0]              evt_mem [EVENT_DEPTH];
	logic [REPORT_BUTTONS-1:0] wr_en;
	logic [AW-1:0]           wr_addr [REPORT_BUTTONS];
	logic [3:0]              wr_data [REPORT_BUTTONS];

	// output buffer
	result_item_t            res;
	result_item_t            skid_q;
	logic                    out_valid_q, skid_valid_q;
	logic                    push, pop;

	assign in_stall  = skid_valid_q;
	assign out_valid = out_valid_q;
	assign push      = in_valid && !skid_valid_q;
	assign pop       = out_valid_q && !out_stall;

	function automatic logic signed [15:0] clamp_axis(input logic signed [15:0] p,
		input logic signed [15:0] lo, input logic signed [15:0] hi);
		logic signed [15:0] r;
		r = p;
		if (r < lo) r = lo;
		if (r >= hi) r = hi - 16'sd1;
		return r;
	endfunction

	always_comb begin
		logic [FW-1:0]      cnt;
		logic [SW-1:0]      tail;
		logic signed [16:0] wsum;
		logic [2:0]         s;
		logic               ev, evp;
		logic [3:0]         e;
		held_d        = held_q;
		press_cnt_d   = press_cnt_q;
		release_cnt_d = release_cnt_q;
		mask_d        = mask_q;
		sum_x_d       = sum_x_q;
		sum_y_d       = sum_y_q;
		pos_x_d       = pos_x_q;
		pos_y_d       = pos_y_q;
		wheel_d       = wheel_q;
		fill_d        = fill_q;
		head_d        = head_q;
		wr_en         = '0;
		wr_addr       = '{default: '0};
		wr_data       = '{default: '0};
		res           = '0;
		cnt           = '0;
		tail          = '0;
		wsum          = '0;
		s             = '0;
		ev            = 1'b0;
		evp           = 1'b0;
		e             = '0;
		unique case (in_item.mode)
			MODE_REPORT: begin
				if (suspend_q) begin
					mask_d  = '0;
					sum_x_d = '0;
					sum_y_d = '0;
				end else begin
					for (int b = 0; b < REPORT_BUTTONS; b++) begin
						s   = REPORT_SLOT[b];
						ev  = 1'b0;
						evp = 1'b0;
						// press wins while up, release only counts while down
						if (in_item.press_flags[b] && !held_q[s]) begin
							press_cnt_d[s] = press_cnt_q[s] + 8'd1;
							held_d[s]      = 1'b1;
							mask_d[s]      = 1'b1;
							ev             = 1'b1;
							evp            = 1'b1;
						end else if (in_item.release_flags[b] && held_q[s]) begin
							release_cnt_d[s] = release_cnt_q[s] + 8'd1;
							held_d[s]        = 1'b0;
							mask_d[s]        = 1'b0;
							ev               = 1'b1;
						end
						if (ev && (fill_q + cnt < DEPTH_F)) begin
							tail = SW'(head_q) + SW'(fill_q + cnt);
							if (tail >= DEPTH_S) tail = tail - DEPTH_S;
							wr_en[b]   = 1'b1;
							wr_addr[b] = tail[AW-1:0];
							wr_data[b] = {evp, s};
							cnt        = cnt + FW'(1);
						end
					end
					fill_d = fill_q + cnt;
					if (in_item.wheel_present) begin
						wsum    = wheel_q + 17'(in_item.wheel_amount);
						wheel_d = wsum;
						if (wsum >= WHEEL_STEP_UP) begin
							press_cnt_d[SLOT_WHEEL_UP]   = press_cnt_q[SLOT_WHEEL_UP] + 8'd1;
							release_cnt_d[SLOT_WHEEL_UP] = release_cnt_q[SLOT_WHEEL_UP] + 8'd1;
							held_d[SLOT_WHEEL_UP]        = 1'b1;
							wheel_d                      = '0;
						end else if (wsum <= WHEEL_STEP_DOWN) begin
							press_cnt_d[SLOT_WHEEL_DOWN]   = press_cnt_q[SLOT_WHEEL_DOWN] + 8'd1;
							release_cnt_d[SLOT_WHEEL_DOWN] = release_cnt_q[SLOT_WHEEL_DOWN] + 8'd1;
							held_d[SLOT_WHEEL_DOWN]        = 1'b1;
							wheel_d                        = '0;
						end
					end
					sum_x_d = sum_x_q + in_item.move_x;
					sum_y_d = sum_y_q + in_item.move_y;
					pos_x_d = clamp_axis(pos_x_q + in_item.move_x, area_left_q, area_right_q);
					pos_y_d = clamp_axis(pos_y_q + in_item.move_y, area_top_q, area_bottom_q);
				end
			end
			MODE_FRAME: begin
				mask_d = held_q;
			end
			MODE_STATE: begin
				res.pos_x     = pos_x_q;
				res.pos_y     = pos_y_q;
				res.delta_x   = sum_x_q;
				res.delta_y   = sum_y_q;
				res.held_mask = mask_q;
				sum_x_d       = '0;
				sum_y_d       = '0;
				mask_d        = '0;
				held_d[SLOT_WHEEL_UP]   = 1'b0;
				held_d[SLOT_WHEEL_DOWN] = 1'b0;
			end
			MODE_DOWN_COUNT: begin
				res.count_value                  = press_cnt_q[in_item.button_index];
				press_cnt_d[in_item.button_index] = '0;
			end
			MODE_UP_COUNT: begin
				res.count_value                    = release_cnt_q[in_item.button_index];
				release_cnt_d[in_item.button_index] = '0;
			end
			MODE_POP: begin
				if (fill_q != '0) begin
					e                 = evt_mem[head_q];
					res.event_valid   = 1'b1;
					res.event_button  = e[2:0];
					res.event_pressed = e[3];
					head_d            = (head_q == LAST_A) ? '0 : head_q + AW'(1);
					fill_d            = fill_q - FW'(1);
				end
			end
			MODE_FLUSH: begin
				held_d        = '0;
				press_cnt_d   = '{default: '0};
				release_cnt_d = '{default: '0};
				fill_d        = '0;
				head_d        = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_left_q   <= AREA_LEFT_RESET;
			area_top_q    <= AREA_TOP_RESET;
			area_right_q  <= AREA_RIGHT_RESET;
			area_bottom_q <= AREA_BOTTOM_RESET;
			suspend_q     <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_AREA_LEFT:   area_left_q   <= cfg_data;
				REG_AREA_TOP:    area_top_q    <= cfg_data;
				REG_AREA_RIGHT:  area_right_q  <= cfg_data;
				REG_AREA_BOTTOM: area_bottom_q <= cfg_data;
				REG_SUSPEND:     suspend_q     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q        <= '0;
			press_cnt_q   <= '{default: '0};
			release_cnt_q <= '{default: '0};
			mask_q        <= '0;
			sum_x_q       <= '0;
			sum_y_q       <= '0;
			pos_x_q       <= POS_X_RESET;
			pos_y_q       <= POS_Y_RESET;
			wheel_q       <= '0;
			fill_q        <= '0;
			head_q        <= '0;
		end else if (push) begin
			held_q        <= held_d;
			press_cnt_q   <= press_cnt_d;
			release_cnt_q <= release_cnt_d;
			mask_q        <= mask_d;
			sum_x_q       <= sum_x_d;
			sum_y_q       <= sum_y_d;
			pos_x_q       <= pos_x_d;
			pos_y_q       <= pos_y_d;
			wheel_q       <= wheel_d;
			fill_q        <= fill_d;
			head_q        <= head_d;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			for (int b = 0; b < REPORT_BUTTONS; b++) begin
				if (wr_en[b]) evt_mem[wr_addr[b]] <= wr_data[b];
			end
		end
	end

	// two-entry output buffer: out_item is the head, skid_q the overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) skid_valid_q <= 1'b1;
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) out_item <= skid_q;
		end else if (push) begin
			if (out_valid_q && !pop) skid_q <= res;
			else out_item <= res;
		end
	end

`ifndef SYNTHESIS
	a_skid_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without a head result");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q <= DEPTH_F) && (head_q <= LAST_A))
		else $error("event queue fill or head out of range");

	a_wheel_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wheel_q > WHEEL_STEP_DOWN) && (wheel_q < WHEEL_STEP_UP))
		else $error("wheel sum left its open range");

	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(push && in_item.mode == MODE_FLUSH) |=> (fill_q == '0 && head_q == '0 && held_q == '0))
		else $error("flush left queue or buttons set");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(push && in_item.mode == MODE_POP && fill_q == '0) |=> (fill_q == '0 && $stable(head_q)))
		else $error("pop of empty queue moved pointers");
`endif

endmodule
